>>> rtl/awbd_pkg.sv
// Shared constants, configuration codes and pixel payload types of the box downscaler.
`default_nettype none

package awbd_pkg;

  localparam int CHAN_W    = 8;
  localparam int COORD_W   = 10;
  localparam int DIM_W     = 11;
  localparam int SHIFT_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_LIMIT = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK     = 2'd2;

  localparam logic [DIM_W-1:0]   RST_SRC_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT = 11'd1024;
  localparam logic [SHIFT_W-1:0] RST_SHRINK     = 2'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  blue_out;
    logic [CHAN_W-1:0]  green_out;
    logic [CHAN_W-1:0]  red_out;
    logic [CHAN_W-1:0]  alpha_out;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               end_of_image;
  } pix_out_t;

endpackage

`default_nettype wire

>>> rtl/awbd_stream_if.sv
// Valid/ready stream interface that carries one pixel payload per transaction.
`default_nettype none

interface awbd_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

>>> rtl/awbd_divider.sv
// Shared restoring divider that produces an eight-bit quotient, one bit per cycle.
`default_nettype none

module awbd_divider #(
  parameter int DVD_W = 22,
  parameter int DVS_W = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [DVD_W-1:0]            dividend_i,
  input  logic [DVS_W-1:0]            divisor_i,
  output logic                        done_o,
  output logic [awbd_pkg::CHAN_W-1:0] quotient_o
);

  localparam int QW     = awbd_pkg::CHAN_W;
  localparam int STEP_W = $clog2(QW);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [DVD_W-1:0]  rem_q;
  logic [DVD_W-1:0]  den_q;
  logic [QW-1:0]     quo_q;
  logic [DVD_W:0]    diff;
  logic              ge;
  logic              last_step;

  assign diff      = {1'b0, rem_q} - {1'b0, den_q};
  assign ge        = !diff[DVD_W];
  assign last_step = (step_q == STEP_W'(QW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= DVD_W'(divisor_i) << (QW - 1);
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= diff[DVD_W-1:0];
      end
      den_q <= den_q >> 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/awbd_store.sv
// Per-column accumulator memory with one write port and one registered read port.
`default_nettype none

module awbd_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 111
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/alpha_weighted_box_downscaler.sv
// Top level of the alpha-weighted box downscaler with its sequencer and accumulator datapath.
// Usage: source pixels enter on pix_i in raster order, one transaction per pixel, and
// shrunk pixels leave on pix_o with their output column, row and an end-of-image flag.
// The geometry is set through cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle;
// every write restarts the image at the top left corner.
// Each pixel passes from acceptance back to ready through one memory read, one load,
// three passes through the shared 8x8 multiplier and one write back. A pixel that closes
// a block adds four divisions on the shared one-bit-per-cycle divider, or a single
// division when the block holds no alpha, and a last step to hand the result to the
// output register. In pass-through mode a pixel goes from acceptance straight to the
// output register.
// The accumulator memory needs no clearing pass: the first pixel of each block overwrites
// its entry, so the block is ready right after reset.
// Reset restores a 1024x1024 image with a block edge of two pixels and empties the
// output register. A finished result waits in the output register while the receiver
// stalls; the block keeps working on the next pixel and waits only when a second result
// is ready before the first has been taken.
`default_nettype none

module alpha_weighted_box_downscaler #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_SHRINK = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  awbd_stream_if.sink                          pix_i,
  awbd_stream_if.source                        pix_o,
  input  logic                                 cfg_we_i,
  input  logic [awbd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [awbd_pkg::DIM_W-1:0]           cfg_data_i
);

  localparam int CHAN_W  = awbd_pkg::CHAN_W;
  localparam int COORD_W = awbd_pkg::COORD_W;
  localparam int DIM_W   = awbd_pkg::DIM_W;
  localparam int SHIFT_W = awbd_pkg::SHIFT_W;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int DEPTH   = MAX_WIDTH / 2;
  localparam int OX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NS      = 2 * MAX_SHRINK;
  localparam int AS_W    = CHAN_W + NS;
  localparam int WS_W    = 2 * CHAN_W + NS;
  localparam int CNT_W   = NS + 1;
  localparam int FC_W    = 3 * CHAN_W;
  localparam int ENT_W   = FC_W + CNT_W + AS_W + 3 * WS_W;
  localparam int CW      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int XW      = (COL_W > COORD_W) ? COL_W : COORD_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_WB   = 3'd3;
  localparam logic [2:0] ST_DST  = 3'd4;
  localparam logic [2:0] ST_DWT  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  localparam logic [1:0] CH_BLUE   = 2'd0;
  localparam logic [1:0] CH_GREEN  = 2'd1;
  localparam logic [1:0] CH_RED    = 2'd2;
  localparam logic [1:0] DIV_ALPHA = 2'd3;

  logic [2:0]         st_q;
  logic [1:0]         m_q;
  logic [1:0]         k_q;
  logic               out_valid_q;
  logic [DIM_W-1:0]   sw_q;
  logic [DIM_W-1:0]   sh_q;
  logic [SHIFT_W-1:0] shrink_q;
  logic [COL_W-1:0]   col_q;
  logic [COORD_W-1:0] row_q;

  awbd_pkg::pix_in_t  pix_q;
  awbd_pkg::pix_out_t res_q;
  logic [COL_W-1:0]   col_pix_q;
  logic [COORD_W-1:0] row_pix_q;
  logic [SHIFT_W-1:0] s_q;
  logic [OX_W-1:0]    ox_q;
  logic               first_q;
  logic               bend_q;
  logic               eoi_q;
  logic [WS_W-1:0]    ws_q [3];
  logic [AS_W-1:0]    asum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [FC_W-1:0]    fc_q;
  logic [CHAN_W-1:0]  qc_q [3];
  logic [CHAN_W-1:0]  qa_q;

  logic [CW-1:0]      sw_ext;
  logic [CW-1:0]      lc_w;
  logic [COL_W-1:0]   last_col;
  logic [DIM_W-1:0]   lr_w;
  logic [COORD_W-1:0] last_row;
  logic [SHIFT_W-1:0] s_sat;
  logic [SHIFT_W-1:0] s_eff;
  logic [2:0]         mask;
  logic               pass_n;
  logic [2:0]         clo;
  logic [2:0]         rlo;
  logic [COL_W-1:0]   cs;
  logic [OX_W-1:0]    ox_n;
  logic               accept;
  logic               out_free;
  logic               emit;

  logic [ENT_W-1:0]   rdata;
  logic [ENT_W-1:0]   wdata;
  logic [WS_W-1:0]    rd_ws [3];
  logic [AS_W-1:0]    rd_as;
  logic [CNT_W-1:0]   rd_cnt;
  logic [FC_W-1:0]    rd_fc;

  logic [CHAN_W-1:0]   chan_sel;
  logic [2*CHAN_W-1:0] prod;
  logic [WS_W-1:0]     ws_sel;
  logic [WS_W-1:0]     div_dvd;
  logic [AS_W-1:0]     div_dvs;
  logic                div_start;
  logic                div_done;
  logic [CHAN_W-1:0]   div_quo;
  logic [XW-1:0]       x_wide;

  assign sw_ext = CW'(sw_q);

  always_comb begin
    if (sw_q == '0) begin
      lc_w = '0;
    end else if (sw_ext > CW'(MAX_WIDTH)) begin
      lc_w = CW'(MAX_WIDTH - 1);
    end else begin
      lc_w = sw_ext - 1'b1;
    end
    if (sh_q == '0) begin
      lr_w = '0;
    end else if (sh_q > DIM_W'(awbd_pkg::ROW_LIMIT)) begin
      lr_w = DIM_W'(awbd_pkg::ROW_LIMIT - 1);
    end else begin
      lr_w = sh_q - 1'b1;
    end
  end

  assign last_col = lc_w[COL_W-1:0];
  assign last_row = lr_w[COORD_W-1:0];

  assign s_sat  = ({1'b0, shrink_q} > 3'(MAX_SHRINK)) ? SHIFT_W'(MAX_SHRINK) : shrink_q;
  assign mask   = 3'((4'd1 << s_sat) - 4'd1);
  assign pass_n = (s_sat == '0) || (CW'(last_col) < CW'(mask)) ||
                  (last_row < COORD_W'(mask));
  assign s_eff  = pass_n ? '0 : s_sat;
  assign clo    = 3'(col_q) & mask;
  assign rlo    = 3'(row_q) & mask;
  assign cs     = col_q >> s_eff;
  assign ox_n   = ({1'b0, cs} >= (COL_W + 1)'(DEPTH)) ? OX_W'(cs - COL_W'(DEPTH))
                                                      : OX_W'(cs);

  assign pix_i.ready = (st_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign out_free    = !out_valid_q || pix_o.ready;
  assign emit        = (st_q == ST_EMIT) && out_free;
  assign div_start   = (st_q == ST_DST);

  assign pix_o.valid   = out_valid_q;
  assign pix_o.payload = res_q;

  assign rd_ws[0] = rdata[WS_W-1:0];
  assign rd_ws[1] = rdata[2*WS_W-1:WS_W];
  assign rd_ws[2] = rdata[3*WS_W-1:2*WS_W];
  assign rd_as    = rdata[3*WS_W+AS_W-1:3*WS_W];
  assign rd_cnt   = rdata[3*WS_W+AS_W+CNT_W-1:3*WS_W+AS_W];
  assign rd_fc    = rdata[ENT_W-1:ENT_W-FC_W];
  assign wdata    = {fc_q, cnt_q, asum_q, ws_q[2], ws_q[1], ws_q[0]};

  always_comb begin
    case (m_q)
      CH_BLUE:  chan_sel = pix_q.blue_in;
      CH_GREEN: chan_sel = pix_q.green_in;
      default:  chan_sel = pix_q.red_in;
    endcase
    case (k_q)
      CH_BLUE:  ws_sel = ws_q[0];
      CH_GREEN: ws_sel = ws_q[1];
      default:  ws_sel = ws_q[2];
    endcase
  end

  assign prod    = chan_sel * pix_q.alpha_in;
  assign div_dvd = (k_q == DIV_ALPHA) ? WS_W'(asum_q) : ws_sel;
  assign div_dvs = (k_q == DIV_ALPHA) ? AS_W'(cnt_q) : asum_q;
  assign x_wide  = XW'(col_pix_q) >> s_q;

  awbd_store #(
    .DEPTH (DEPTH),
    .AW    (OX_W),
    .DW    (ENT_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_q == ST_WB),
    .waddr_i (ox_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (ox_n),
    .rdata_o (rdata)
  );

  awbd_divider #(
    .DVD_W (WS_W),
    .DVS_W (AS_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      m_q         <= CH_BLUE;
      k_q         <= CH_BLUE;
      out_valid_q <= 1'b0;
      sw_q        <= awbd_pkg::RST_SRC_WIDTH;
      sh_q        <= awbd_pkg::RST_SRC_HEIGHT;
      shrink_q    <= awbd_pkg::RST_SHRINK;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          awbd_pkg::CFG_SRC_WIDTH:  sw_q     <= cfg_data_i;
          awbd_pkg::CFG_SRC_HEIGHT: sh_q     <= cfg_data_i;
          awbd_pkg::CFG_SHRINK:     shrink_q <= cfg_data_i[SHIFT_W-1:0];
          default: ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        if (col_q == last_col) begin
          col_q <= '0;
          row_q <= (row_q == last_row) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end

      case (st_q)
        ST_IDLE: begin
          if (accept) begin
            st_q <= pass_n ? ST_EMIT : ST_LOAD;
          end
        end
        ST_LOAD: begin
          m_q  <= CH_BLUE;
          st_q <= ST_MUL;
        end
        ST_MUL: begin
          if (m_q == CH_RED) begin
            st_q <= ST_WB;
          end else begin
            m_q <= m_q + 1'b1;
          end
        end
        ST_WB: begin
          if (bend_q) begin
            k_q  <= (asum_q == '0) ? DIV_ALPHA : CH_BLUE;
            st_q <= ST_DST;
          end else begin
            st_q <= ST_IDLE;
          end
        end
        ST_DST: begin
          st_q <= ST_DWT;
        end
        ST_DWT: begin
          if (div_done) begin
            if (k_q == DIV_ALPHA) begin
              st_q <= ST_EMIT;
            end else begin
              k_q  <= k_q + 1'b1;
              st_q <= ST_DST;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            st_q <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q     <= pix_i.payload;
      col_pix_q <= col_q;
      row_pix_q <= row_q;
      s_q       <= s_eff;
      ox_q      <= ox_n;
      first_q   <= (clo == 3'd0) && (rlo == 3'd0);
      bend_q    <= ((clo == mask) || (col_q == last_col)) &&
                   ((rlo == mask) || (row_q == last_row));
      eoi_q     <= (col_q == last_col) && (row_q == last_row);
    end

    if (st_q == ST_LOAD) begin
      if (first_q) begin
        ws_q[0] <= '0;
        ws_q[1] <= '0;
        ws_q[2] <= '0;
        asum_q  <= AS_W'(pix_q.alpha_in);
        cnt_q   <= CNT_W'(1);
        fc_q    <= {pix_q.red_in, pix_q.green_in, pix_q.blue_in};
      end else begin
        ws_q[0] <= rd_ws[0];
        ws_q[1] <= rd_ws[1];
        ws_q[2] <= rd_ws[2];
        asum_q  <= rd_as + AS_W'(pix_q.alpha_in);
        cnt_q   <= rd_cnt + 1'b1;
        fc_q    <= rd_fc;
      end
    end

    if (st_q == ST_MUL) begin
      case (m_q)
        CH_BLUE:  ws_q[0] <= ws_q[0] + WS_W'(prod);
        CH_GREEN: ws_q[1] <= ws_q[1] + WS_W'(prod);
        default:  ws_q[2] <= ws_q[2] + WS_W'(prod);
      endcase
    end

    if (st_q == ST_WB) begin
      qc_q[0] <= fc_q[CHAN_W-1:0];
      qc_q[1] <= fc_q[2*CHAN_W-1:CHAN_W];
      qc_q[2] <= fc_q[3*CHAN_W-1:2*CHAN_W];
    end

    if ((st_q == ST_DWT) && div_done) begin
      case (k_q)
        CH_BLUE:  qc_q[0] <= div_quo;
        CH_GREEN: qc_q[1] <= div_quo;
        CH_RED:   qc_q[2] <= div_quo;
        default:  qa_q    <= div_quo;
      endcase
    end

    if (emit) begin
      if (s_q == '0) begin
        res_q.blue_out  <= pix_q.blue_in;
        res_q.green_out <= pix_q.green_in;
        res_q.red_out   <= pix_q.red_in;
        res_q.alpha_out <= pix_q.alpha_in;
      end else begin
        res_q.blue_out  <= qc_q[0];
        res_q.green_out <= qc_q[1];
        res_q.red_out   <= qc_q[2];
        res_q.alpha_out <= qa_q;
      end
      res_q.out_x        <= x_wide[COORD_W-1:0];
      res_q.out_y        <= row_pix_q >> s_q;
      res_q.end_of_image <= eoi_q;
    end
  end

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= last_col)
    else $error("Column position beyond the last source column.");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= last_row)
    else $error("Row position beyond the last source row.");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == ST_DWT))
    else $error("Divider finished while the sequencer was not waiting for it.");

  a_div_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DST) |-> (cnt_q != '0))
    else $error("Division started on a block without samples.");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench of the alpha-weighted box downscaler: directed and random images checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CHAN_W = awbd_pkg::CHAN_W;
  localparam int COORD_W = awbd_pkg::COORD_W;
  localparam int DIM_W = awbd_pkg::DIM_W;
  localparam int SHIFT_W = awbd_pkg::SHIFT_W;
  localparam int CFG_IDX_W = awbd_pkg::CFG_IDX_W;
  localparam int ROW_LIMIT = awbd_pkg::ROW_LIMIT;
  localparam int MAX_W = 1024;
  localparam int MAX_SHIFT = 3;
  localparam int COLUMNS = MAX_W / 2;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PIXELS = 450;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DIM_W-1:0] cfg_data_i = '0;

  awbd_stream_if #(.payload_t(awbd_pkg::pix_in_t)) pix_in_if ();
  awbd_stream_if #(.payload_t(awbd_pkg::pix_out_t)) pix_out_if ();

  alpha_weighted_box_downscaler u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix_in_if),
    .pix_o     (pix_out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [DIM_W-1:0] img_width = awbd_pkg::RST_SRC_WIDTH;
  logic [DIM_W-1:0] img_height = awbd_pkg::RST_SRC_HEIGHT;
  logic [SHIFT_W-1:0] img_shift = awbd_pkg::RST_SHRINK;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned alpha_sum [COLUMNS];
  int unsigned blue_sum [COLUMNS];
  int unsigned green_sum [COLUMNS];
  int unsigned red_sum [COLUMNS];
  int unsigned sample_count [COLUMNS];
  logic [23:0] first_colour [COLUMNS];

  awbd_pkg::pix_out_t pending_pixels[$];
  awbd_pkg::pix_out_t want_pix;
  awbd_pkg::pix_out_t got_pix;
  int unsigned mismatches = 0;
  bit no_idle = 1'b0;

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    return (v > limit) ? limit : v;
  endfunction

  function automatic void downscale_pixel(input awbd_pkg::pix_in_t p);
    int unsigned w, h, s, c, r, mask, ox, sa, n;
    bit last_col, last_row;
    awbd_pkg::pix_out_t res;
    w = clamp_dim(img_width, MAX_W);
    h = clamp_dim(img_height, ROW_LIMIT);
    s = (img_shift > MAX_SHIFT) ? MAX_SHIFT : img_shift;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    if (s != 0 && (w < (1 << s) || h < (1 << s))) s = 0;
    if (s == 0) begin
      res.blue_out = p.blue_in;
      res.green_out = p.green_in;
      res.red_out = p.red_in;
      res.alpha_out = p.alpha_in;
      res.out_x = c[COORD_W-1:0];
      res.out_y = r[COORD_W-1:0];
      res.end_of_image = last_col && last_row;
      pending_pixels.push_back(res);
    end else begin
      mask = (1 << s) - 1;
      ox = (c >> s) % COLUMNS;
      if ((c & mask) == 0 && (r & mask) == 0) begin
        alpha_sum[ox] = 0;
        blue_sum[ox] = 0;
        green_sum[ox] = 0;
        red_sum[ox] = 0;
        sample_count[ox] = 0;
        first_colour[ox] = {p.red_in, p.green_in, p.blue_in};
      end
      alpha_sum[ox] += p.alpha_in;
      blue_sum[ox] += p.blue_in * p.alpha_in;
      green_sum[ox] += p.green_in * p.alpha_in;
      red_sum[ox] += p.red_in * p.alpha_in;
      sample_count[ox] += 1;
      if (((c & mask) == mask || last_col) && ((r & mask) == mask || last_row)) begin
        sa = alpha_sum[ox];
        n = sample_count[ox];
        if (sa != 0) begin
          res.blue_out = CHAN_W'(blue_sum[ox] / sa);
          res.green_out = CHAN_W'(green_sum[ox] / sa);
          res.red_out = CHAN_W'(red_sum[ox] / sa);
        end else begin
          res.blue_out = first_colour[ox][7:0];
          res.green_out = first_colour[ox][15:8];
          res.red_out = first_colour[ox][23:16];
        end
        res.alpha_out = (n != 0) ? CHAN_W'(sa / n) : '0;
        res.out_x = COORD_W'(c >> s);
        res.out_y = COORD_W'(r >> s);
        res.end_of_image = last_col && last_row;
        pending_pixels.push_back(res);
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [COORD_W-1:0] want,
                                        input logic [COORD_W-1:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pix_out_if.valid && pix_out_if.ready) begin
      got_pix = pix_out_if.payload;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output pixel, expected none, actual %p", $time, got_pix);
        mismatches++;
      end else begin
        want_pix = pending_pixels.pop_front();
        compare_field("blue_out", COORD_W'(want_pix.blue_out), COORD_W'(got_pix.blue_out));
        compare_field("green_out", COORD_W'(want_pix.green_out), COORD_W'(got_pix.green_out));
        compare_field("red_out", COORD_W'(want_pix.red_out), COORD_W'(got_pix.red_out));
        compare_field("alpha_out", COORD_W'(want_pix.alpha_out), COORD_W'(got_pix.alpha_out));
        compare_field("out_x", want_pix.out_x, got_pix.out_x);
        compare_field("out_y", want_pix.out_y, got_pix.out_y);
        compare_field("end_of_image", COORD_W'(want_pix.end_of_image),
                      COORD_W'(got_pix.end_of_image));
      end
    end
  end

  initial begin
    int stall;
    pix_out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        pix_out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      pix_out_if.ready = 1'b1;
      do @(posedge clk_i); while (!pix_out_if.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_pixel(input awbd_pkg::pix_in_t p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pix_in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_in_if.valid = 1'b1;
    pix_in_if.payload = p;
    do @(posedge clk_i); while (!pix_in_if.ready);
    downscale_pixel(p);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      awbd_pkg::CFG_SRC_WIDTH: img_width = data;
      awbd_pkg::CFG_SRC_HEIGHT: img_height = data;
      awbd_pkg::CFG_SHRINK: img_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [DIM_W-1:0] shift_data);
    write_reg(awbd_pkg::CFG_SRC_WIDTH, w);
    write_reg(awbd_pkg::CFG_SRC_HEIGHT, h);
    write_reg(awbd_pkg::CFG_SHRINK, shift_data);
  endtask

  task automatic settle();
    pix_in_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic awbd_pkg::pix_in_t random_pixel(input bit zero_alpha);
    awbd_pkg::pix_in_t p;
    p.blue_in = CHAN_W'($urandom_range(0, 255));
    p.green_in = CHAN_W'($urandom_range(0, 255));
    p.red_in = CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: p.alpha_in = 8'd0;
      1: p.alpha_in = 8'd255;
      default: p.alpha_in = CHAN_W'($urandom_range(0, 255));
    endcase
    if (zero_alpha) p.alpha_in = 8'd0;
    return p;
  endfunction

  task automatic test_reset_geometry();
    repeat (3) send_pixel(random_pixel(1'b0));
    settle();
    write_reg(CFG_SPARE, 11'h7ff);
  endtask

  task automatic test_oversize_geometry();
    set_geometry(11'd2047, 11'd2047, 11'd0);
    repeat (3) send_pixel(random_pixel(1'b0));
    settle();
  endtask

  task automatic test_pass_through();
    set_geometry(11'd2, 11'd2, 11'd0);
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd255});
    send_pixel('{8'haa, 8'h55, 8'haa, 8'h55});
    send_pixel('{8'h55, 8'haa, 8'h55, 8'haa});
    settle();
  endtask

  task automatic test_zero_size();
    set_geometry(11'd0, 11'd0, 11'd3);
    repeat (2) send_pixel(random_pixel(1'b0));
    settle();
  endtask

  task automatic test_alpha_weighting();
    set_geometry(11'd2, 11'd2, 11'd1);
    send_pixel('{8'd255, 8'd0, 8'd128, 8'd255});
    send_pixel('{8'd0, 8'd255, 8'd64, 8'd1});
    send_pixel('{8'd10, 8'd20, 8'd30, 8'd0});
    send_pixel('{8'd200, 8'd100, 8'd50, 8'd128});
    // With no alpha at all the block takes the colour of its first pixel.
    send_pixel('{8'h12, 8'h34, 8'h56, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0});
    send_pixel('{8'd7, 8'd8, 8'd9, 8'd0});
    settle();
  endtask

  task automatic test_clipped_blocks();
    no_idle = 1'b1;
    set_geometry(11'd3, 11'd3, 11'd1);
    repeat (9) send_pixel(random_pixel(1'b0));
    settle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_images();
    int unsigned w, h, total, n, sent;
    logic [SHIFT_W-1:0] s;
    bit zero_alpha;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(21, 2047);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 12);
      end
      s = SHIFT_W'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, DIM_W'($urandom_range(0, 2047)));
      set_geometry(DIM_W'(w), DIM_W'(h), {(DIM_W - SHIFT_W)'($urandom_range(0, 511)), s});
      total = clamp_dim(DIM_W'(w), MAX_W) * clamp_dim(DIM_W'(h), ROW_LIMIT);
      if (total > 240 || $urandom_range(0, 4) == 0)
        n = $urandom_range(1, (total > 240) ? 240 : total);
      else
        n = total * $urandom_range(1, 2);
      if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
      zero_alpha = ($urandom_range(0, 5) == 0);
      repeat (n) send_pixel(random_pixel(zero_alpha));
      sent += n;
      settle();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    pix_in_if.valid = 1'b0;
    pix_in_if.payload = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_geometry();
    test_oversize_geometry();
    test_pass_through();
    test_zero_size();
    test_alpha_weighting();
    test_clipped_blocks();
    test_random_images();
    settle();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/awbd_pkg.sv
rtl/awbd_stream_if.sv
rtl/awbd_divider.sv
rtl/awbd_store.sv
rtl/alpha_weighted_box_downscaler.sv
tb/tb.sv
